/* rtl/bia_pkg.sv */
package bia_pkg;

    // Bitmap geometry
    localparam int WORD_BITS  = 32;
    localparam int WORD_COUNT = 8;
    localparam int ID_COUNT   = WORD_COUNT * WORD_BITS;

    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int WIDX_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int ID_W   = BIT_W + WIDX_W;
    localparam int STEP_W = $clog2(WORD_COUNT + 1);

    // Port field widths
    localparam int OP_W      = 3;
    localparam int IN_ID_W   = 9;
    localparam int GRANT_W   = 8;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 3'd0,
        OP_FREE    = 3'd1,
        OP_RESERVE = 3'd2,
        OP_QUERY   = 3'd3,
        OP_CLEAR   = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture the accepted request
        logic scan_init;  // start a next-fit scan at the search pointer
        logic scan_step;  // examine one bitmap word
        logic rd_scan;    // read port follows the scan word
        logic commit;     // update state and load the output register
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_alloc;   // request on the input is an allocate
        logic scan_done;  // free bit found or last word examined
        logic out_free;   // output register can take a result
    } dp_status_t;

endpackage

/* rtl/bia_ctrl.sv */
module bia_ctrl
    import bia_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load      = 1'b1;
                    cmd.scan_init = status.in_alloc;
                    state_next    = status.in_alloc ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_scan   = 1'b1;
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Hold until the result can be placed in the output register
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/bia_datapath.sv */
module bia_datapath
    import bia_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]      s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0]  m_tuser,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status
);

    logic [WORD_BITS-1:0] usage_reg [WORD_COUNT];
    logic [ID_W-1:0]      ptr_reg;

    logic [OP_W-1:0]      op_reg;
    logic [IN_ID_W-1:0]   id_reg;

    logic [WIDX_W-1:0]    cur_word_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 res_found_reg;
    logic [ID_W-1:0]      res_id_reg;

    logic                 out_valid_reg;
    logic [GRANT_W-1:0]   out_grant_reg;
    logic                 out_marked_reg;
    logic [STATUS_W-1:0]  out_status_reg;

    logic [WIDX_W-1:0]    rd_idx;
    logic [WORD_BITS-1:0] rd_word;
    logic [WORD_BITS-1:0] ge_mask;
    logic [WORD_BITS-1:0] scan_mask;
    logic [WORD_BITS-1:0] cand;
    logic [WORD_BITS-1:0] lowest;
    logic [BIT_W-1:0]     hit_bit;
    logic                 hit;
    logic                 last_step;
    logic                 in_range;
    logic [WIDX_W-1:0]    id_word;
    logic [BIT_W-1:0]     id_bit;
    logic [ID_W-1:0]      ptr_wrap;

    assign id_word  = id_reg[ID_W-1:BIT_W];
    assign id_bit   = id_reg[BIT_W-1:0];
    assign in_range = id_reg < IN_ID_W'(ID_COUNT);
    assign ptr_wrap = (ptr_reg == ID_W'(ID_COUNT - 1)) ? '0 : ptr_reg + 1'b1;

    // Single read port into the bitmap
    assign rd_idx  = cmd.rd_scan ? cur_word_reg : id_word;
    assign rd_word = usage_reg[rd_idx];

    // First word starts at the pointer bit, the wrapped revisit stops below it
    assign ge_mask   = {WORD_BITS{1'b1}} << ptr_reg[BIT_W-1:0];
    assign last_step = step_reg == STEP_W'(WORD_COUNT);
    always_comb
    begin
        if (step_reg == '0)
        begin
            scan_mask = ge_mask;
        end
        else if (last_step)
        begin
            scan_mask = ~ge_mask;
        end
        else
        begin
            scan_mask = '1;
        end
    end

    // Lowest free bit: isolate it, then encode the one-hot position
    assign cand   = ~rd_word & scan_mask;
    assign lowest = cand & (~cand + 1'b1);
    assign hit    = |cand;
    always_comb
    begin
        hit_bit = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (lowest[b])
            begin
                hit_bit = hit_bit | BIT_W'(b);
            end
        end
    end

    assign status.in_alloc  = s_tuser == OP_ALLOC;
    assign status.scan_done = hit || last_step;
    assign status.out_free  = !out_valid_reg || m_tready;

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= s_tuser;
            id_reg <= s_tdata[IN_ID_W-1:0];
        end
    end

    // Scan position and its outcome
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_word_reg  <= '0;
            step_reg      <= '0;
            res_found_reg <= 1'b0;
        end
        else if (cmd.scan_init)
        begin
            cur_word_reg  <= ptr_reg[ID_W-1:BIT_W];
            step_reg      <= '0;
            res_found_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            cur_word_reg  <= (cur_word_reg == WIDX_W'(WORD_COUNT - 1)) ? '0
                                                                        : cur_word_reg + 1'b1;
            step_reg      <= step_reg + 1'b1;
            res_found_reg <= hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            res_id_reg <= {cur_word_reg, hit_bit};
        end
    end

    // Bitmap and search pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < WORD_COUNT; w++)
            begin
                usage_reg[w] <= '0;
            end
            ptr_reg <= '0;
        end
        else if (cmd.commit)
        begin
            unique case (op_reg)
                OP_ALLOC:
                begin
                    if (res_found_reg)
                    begin
                        usage_reg[res_id_reg[ID_W-1:BIT_W]][res_id_reg[BIT_W-1:0]] <= 1'b1;
                        ptr_reg <= res_id_reg;
                    end
                    else
                    begin
                        ptr_reg <= ptr_wrap;
                    end
                end
                OP_FREE, OP_RESERVE:
                begin
                    if (in_range)
                    begin
                        usage_reg[id_word][id_bit] <= (op_reg == OP_RESERVE);
                    end
                end
                OP_CLEAR:
                begin
                    for (int w = 0; w < WORD_COUNT; w++)
                    begin
                        usage_reg[w] <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_grant_reg  <= '0;
            out_marked_reg <= 1'b0;
            out_status_reg <= STATUS_OK;
            unique case (op_reg)
                OP_ALLOC:
                begin
                    if (res_found_reg)
                    begin
                        out_grant_reg <= GRANT_W'(res_id_reg);
                    end
                    else
                    begin
                        out_status_reg <= STATUS_FULL;
                    end
                end
                OP_FREE, OP_RESERVE:
                begin
                    if (!in_range)
                    begin
                        out_status_reg <= STATUS_RANGE;
                    end
                end
                OP_QUERY:
                begin
                    if (in_range)
                    begin
                        out_marked_reg <= rd_word[id_bit];
                    end
                    else
                    begin
                        out_status_reg <= STATUS_RANGE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - GRANT_W - 1){1'b0}}, out_marked_reg, out_grant_reg};
    assign m_tuser  = out_status_reg;

endmodule

/* rtl/bitmap_id_allocator.sv */
// Channel  Direction  Handshake          Payload
// s_*      in         s_tvalid/s_tready  tdata: id_number; tuser: operation
// m_*      out        m_tvalid/m_tready  tdata: granted_id, is_marked; tuser: status
//
// One request at a time. Free, reserve, query and clear pass from the input
// transfer through the finish state into the output register. Allocate first
// runs the scan state, where the next-fit scan examines 1..WORD_COUNT+1 words
// through the single bitmap read port, then commits in the finish state.
// Reset (rst_n low, asynchronous) clears the bitmap and search pointer at once.
// A new request is taken while a result waits; a stalled result holds the next
// one in the controller until the output register frees.
module bitmap_id_allocator
    import bia_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [8:0] id_number, [15:9] zero
    input  logic [OP_W-1:0]      s_tuser,   // [2:0] operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] granted_id, [8] is_marked, [15:9] zero
    output logic [STATUS_W-1:0]  m_tuser    // [1:0] status
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    bia_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bia_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

/* tb/sv/alloc_checker.sv */
`timescale 1ns / 1ps

module alloc_checker
    import bia_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [8:0] id_number, [15:9] zero
    input  logic [OP_W-1:0]      s_tuser,   // [2:0] operation
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // [7:0] granted_id, [8] is_marked, [15:9] zero
    input  logic [STATUS_W-1:0]  m_tuser,   // [1:0] status
    output int                   fail_count,
    output int                   pending,
    output int                   full_count
);

    typedef struct packed {
        logic [GRANT_W-1:0] grant;
        logic               marked;
        status_t            status;
    } alloc_reply_t;

    // Shadow copy of the usage bitmap and the next-fit pointer
    logic [ID_COUNT-1:0] used_map;
    logic [ID_W-1:0]     search_ptr;
    alloc_reply_t        awaited_replies[$];
    int                  errs;
    int                  refused;

    assign fail_count = errs;
    assign full_count = refused;

    // Apply one request to the shadow state and work out its reply
    task automatic serve_request(input logic [OP_W-1:0] op, input logic [IN_ID_W-1:0] id,
                                 output alloc_reply_t reply);
        int probes;
        bit found;
        bit in_range;
        reply    = '0;
        in_range = (id < ID_COUNT);
        case (op)
            OP_ALLOC:
            begin
                // Walk from the pointer, wrapping; a full map ends one past the start
                found  = 1'b0;
                probes = 0;
                while (!found && probes <= ID_COUNT)
                begin
                    if (!used_map[search_ptr])
                        found = 1'b1;
                    else
                    begin
                        search_ptr = (search_ptr == ID_COUNT - 1) ? '0 : search_ptr + 1'b1;
                        probes++;
                    end
                end
                if (found)
                begin
                    used_map[search_ptr] = 1'b1;
                    reply.grant          = search_ptr;
                end
                else
                begin
                    reply.status = STATUS_FULL;
                    refused++;
                end
            end
            OP_FREE, OP_RESERVE:
            begin
                if (in_range)
                    used_map[id[ID_W-1:0]] = (op == OP_RESERVE);
                else
                    reply.status = STATUS_RANGE;
            end
            OP_QUERY:
            begin
                if (in_range)
                    reply.marked = used_map[id[ID_W-1:0]];
                else
                    reply.status = STATUS_RANGE;
            end
            OP_CLEAR:
                used_map = '0;
            default:
                ;
        endcase
    endtask

    // Retire result transfers against the oldest reply, then predict new requests
    always @(posedge clk or negedge rst_n)
    begin
        alloc_reply_t got;
        alloc_reply_t want;
        if (!rst_n)
        begin
            used_map   = '0;
            search_ptr = '0;
            awaited_replies.delete();
            errs       = 0;
            refused    = 0;
            pending   <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.grant  = m_tdata[GRANT_W-1:0];
                got.marked = m_tdata[GRANT_W];
                got.status = status_t'(m_tuser);
                if (awaited_replies.size() == 0)
                begin
                    $error("result transfer with no request outstanding: tdata %h tuser %h",
                           m_tdata, m_tuser);
                    errs++;
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (got.grant !== want.grant)
                    begin
                        $error("granted_id: expected %0d, actual %0d", want.grant, got.grant);
                        errs++;
                    end
                    if (got.marked !== want.marked)
                    begin
                        $error("is_marked: expected %0d, actual %0d", want.marked, got.marked);
                        errs++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                serve_request(s_tuser, s_tdata[IN_ID_W-1:0], want);
                awaited_replies.push_back(want);
            end
            pending <= awaited_replies.size();
        end
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import bia_pkg::*;

    localparam int ITEM_TARGET = 1300;
    localparam int LIMIT       = 400000;
    localparam int IDLE_PCT    = 22;
    localparam int PAUSE_AT    = 500;
    localparam int HOLD_AT     = 700;
    localparam int HOLD_CYCLES = 300;
    localparam int CALM_FROM   = 900;
    localparam int CALM_TO     = 1100;
    localparam int ID_MAX      = (1 << IN_ID_W) - 1;

    // Operation codes the block leaves unused
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]      s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    int fail_count;
    int pending;
    int full_count;
    int sent_count  = 0;
    int cycle_count = 0;
    int range_tally = 0;
    int op_tally[8];
    int hold_left   = 0;
    bit hold_used   = 1'b0;
    logic calm;

    // No idling on either side while the sent count is inside the calm window
    assign calm = (sent_count >= CALM_FROM) && (sent_count < CALM_TO);

    always #4 clk = ~clk;

    bitmap_id_allocator u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    alloc_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending),
        .full_count (full_count)
    );

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: random back-pressure plus one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_used && sent_count >= HOLD_AT)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Mostly in-range identifiers, some beyond the map
    function automatic logic [IN_ID_W-1:0] rand_id();
        if ($urandom_range(99) < 88)
            return IN_ID_W'($urandom_range(ID_COUNT - 1));
        else
            return IN_ID_W'($urandom_range(ID_MAX, ID_COUNT));
    endfunction

    // Offer one request and hold it until the transfer
    task automatic send_req(input logic [OP_W-1:0] op, input logic [IN_ID_W-1:0] id);
        if (sent_count == PAUSE_AT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
        end
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - IN_ID_W){1'b0}}, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_count++;
        op_tally[op]++;
        if ((op == OP_FREE || op == OP_RESERVE || op == OP_QUERY) && id >= ID_COUNT)
            range_tally++;
    endtask

    initial
    begin
        int n;
        int r;
        int mode;
        bit first;
        foreach (op_tally[i])
            op_tally[i] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first grants, queries at the edges, range errors, spare codes
        send_req(OP_ALLOC,   9'd0);
        send_req(OP_ALLOC,   9'd511);
        send_req(OP_QUERY,   9'd0);
        send_req(OP_QUERY,   9'd255);
        send_req(OP_RESERVE, 9'd255);
        send_req(OP_QUERY,   9'd255);
        send_req(OP_QUERY,   9'd256);
        send_req(OP_QUERY,   9'd511);
        send_req(OP_FREE,    9'd511);
        send_req(OP_RESERVE, 9'd256);
        send_req(OP_FREE,    9'd0);
        send_req(OP_ALLOC,   9'h0AA);
        send_req(OP_SPARE_A, 9'd511);
        send_req(OP_SPARE_B, 9'd0);
        send_req(OP_SPARE_C, 9'h155);
        send_req(OP_CLEAR,   9'h155);
        send_req(OP_QUERY,   9'd1);
        send_req(OP_ALLOC,   9'd0);
        send_req(OP_RESERVE, 9'd0);
        send_req(OP_FREE,    9'd255);
        send_req(OP_ALLOC,   9'h1FF);

        // Random: fill runs to exhaustion, churn, and raw noise
        first = 1'b1;
        while (sent_count < ITEM_TARGET)
        begin
            mode  = first ? 0 : $urandom_range(9);
            first = 1'b0;
            if (mode <= 2)
            begin
                send_req(OP_CLEAR, rand_id());
                n = $urandom_range(300, 260);
                repeat (n)
                begin
                    r = $urandom_range(99);
                    if (r < 94)
                        send_req(OP_ALLOC, IN_ID_W'($urandom_range(ID_MAX)));
                    else if (r < 97)
                        send_req(OP_QUERY, rand_id());
                    else
                        send_req(OP_RESERVE, rand_id());
                end
            end
            else if (mode <= 6)
            begin
                n = $urandom_range(80, 40);
                repeat (n)
                begin
                    r = $urandom_range(99);
                    if (r < 35)
                        send_req(OP_ALLOC, IN_ID_W'($urandom_range(ID_MAX)));
                    else if (r < 60)
                        send_req(OP_FREE, rand_id());
                    else if (r < 75)
                        send_req(OP_RESERVE, rand_id());
                    else if (r < 97)
                        send_req(OP_QUERY, rand_id());
                    else
                        send_req(OP_CLEAR, rand_id());
                end
            end
            else
            begin
                n = $urandom_range(40, 20);
                repeat (n)
                    send_req(OP_W'($urandom_range(7)), IN_ID_W'($urandom_range(ID_MAX)));
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding replies, then let the pipeline settle
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d requests: alloc %0d, free %0d, reserve %0d, query %0d, clear %0d",
                 sent_count, op_tally[OP_ALLOC], op_tally[OP_FREE], op_tally[OP_RESERVE],
                 op_tally[OP_QUERY], op_tally[OP_CLEAR]);
        $display("Unused codes %0d, out-of-range ids %0d, allocations refused as full %0d",
                 op_tally[OP_SPARE_A] + op_tally[OP_SPARE_B] + op_tally[OP_SPARE_C],
                 range_tally, full_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/bia_pkg.sv
rtl/bia_ctrl.sv
rtl/bia_datapath.sv
rtl/bitmap_id_allocator.sv
tb/sv/alloc_checker.sv
tb/sv/tb_top.sv
